>>> rtl/mls_pkg.sv
// Shared types, codes and constants of the multilevel lottery scheduler.
package mls_pkg;

    // Operation codes carried in the func field
    localparam logic [2:0] FUNC_ADMIT   = 3'd0;
    localparam logic [2:0] FUNC_SET_RUN = 3'd1;
    localparam logic [2:0] FUNC_SET_LVL = 3'd2;
    localparam logic [2:0] FUNC_SET_TIX = 3'd3;
    localparam logic [2:0] FUNC_SCHED   = 3'd4;

    // Queue levels
    localparam logic [1:0] LEVEL_RR   = 2'd1;
    localparam logic [1:0] LEVEL_LOT  = 2'd2;
    localparam logic [1:0] LEVEL_FCFS = 2'd3;

    localparam logic [30:0] THR_RESET  = 31'd8000;
    localparam logic [31:0] DRAW_MULT  = 32'd132;
    localparam logic [30:0] FCFS_LIMIT = 31'd2000000000;

    typedef struct packed {
        logic [2:0]  func;
        logic [5:0]  slot;
        logic [30:0] now;
        logic [9:0]  tickets;
        logic [1:0]  level;
        logic        runnable;
    } t_in_item;

    typedef struct packed {
        logic       found;
        logic [5:0] chosen_slot;
        logic [1:0] chosen_level;
    } t_out_item;

    // One slot table entry
    typedef struct packed {
        logic        runnable;
        logic [1:0]  level;
        logic [30:0] entered;
        logic [9:0]  tickets;
    } t_entry;

    localparam t_entry ENTRY_RESET = '{runnable: 1'b0, level: LEVEL_LOT,
                                       entered: 31'd0, tickets: 10'd0};

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_SET_RD,
        OP_SET_WR,
        OP_SCAN1,
        OP_DRAW_INIT,
        OP_DIV_A,
        OP_MUL_A,
        OP_MUL_K,
        OP_DIV_E,
        OP_DIV_F,
        OP_MUL_R,
        OP_DIV_R,
        OP_SCAN2,
        OP_COMMIT,
        OP_LOAD_OUT
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   start;
    } t_mls_cmd;

    typedef struct packed {
        logic scan_done;
        logic div_done;
        logic pick1;
        logic small_total;
        logic out_free;
    } t_mls_stat;

endpackage

>>> rtl/mls_div.sv
// Serial signed remainder unit: one quotient bit per cycle, C truncating sign.
module mls_div import mls_pkg::*; #(
    parameter int DW = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_dividend,
    input  logic [DW-1:0]      i_divisor,
    output logic               o_done,
    output logic signed [31:0] o_rem
);

    logic          r_busy;
    logic          r_done;
    logic [4:0]    r_cnt;
    logic [31:0]   r_q;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_dvs;
    logic          r_neg;
    logic [DW:0]   trial;
    logic [DW-1:0] n_rem;

    // Restoring step: shift in next dividend bit, subtract when it fits
    always_comb begin
        trial = {r_rem, r_q[31]};
        if (trial >= {1'b0, r_dvs}) begin
            n_rem = DW'(trial - {1'b0, r_dvs});
        end else begin
            n_rem = trial[DW-1:0];
        end
    end

    // Hold control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == 5'd31);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                end
                r_cnt <= r_cnt + 5'd1;
            end
        end
    end

    // Advance the magnitude and partial remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[31];
            r_q   <= i_dividend[31] ? 32'(-i_dividend) : i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[30:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_neg ? -$signed(32'(r_rem)) : $signed(32'(r_rem));

endmodule

>>> rtl/mls_datapath.sv
// Datapath: slot table memory, scan engine, lottery draw arithmetic, result register.
module mls_datapath import mls_pkg::*; #(
    parameter int SLOTS = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_mls_cmd  i_cmd,
    input  t_in_item  i_in_item,
    input  logic [30:0] i_thr,
    input  logic      i_out_stall,
    output t_mls_stat o_stat,
    output logic      o_out_valid,
    output t_out_item o_out_item
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int TW = SW + 10;
    localparam logic [SW-1:0] LAST = SW'(SLOTS - 1);

    // Slot table and its valid bits
    t_entry           mem [SLOTS];
    logic [SLOTS-1:0] r_valid;
    t_entry           r_rd_word;
    logic             r_rd_vld;
    logic             we;
    logic [SW-1:0]    wa;
    t_entry           wd;
    logic [SW-1:0]    ra;
    t_entry           eff;

    // Captured item
    t_in_item      r_item;
    logic [SW-1:0] slot_idx;
    logic          in_rng;
    logic [31:0]   now32;

    // Scan engine
    logic          r_issuing;
    logic          r_pv;
    logic [SW-1:0] r_cnt;
    logic [SW-1:0] r_pidx;
    logic          is_scan;

    // Scan accumulators
    logic [31:0]   wait32;
    logic          age;
    logic          r_p1_hit;
    logic [30:0]   r_best;
    logic [SW-1:0] r_p1_idx;
    t_entry        r_p1_word;
    logic [TW-1:0] r_total;
    logic signed [33:0] r_w;
    logic signed [33:0] w_next;
    logic          r_lot_hit;
    logic [SW-1:0] r_lot_idx;
    t_entry        r_lot_word;
    logic          r_fc_hit;
    logic [30:0]   r_mn;
    logic [SW-1:0] r_fc_idx;
    t_entry        r_fc_word;

    // Draw arithmetic
    logic [31:0]        r_a;
    logic [31:0]        r_prod;
    logic [31:0]        r_e;
    logic [31:0]        r_f;
    logic signed [31:0] r_draw;
    logic               div_start;
    logic signed [31:0] div_in;
    logic               div_done;
    logic signed [31:0] div_rem;

    // Commit selection and result
    logic          sel_found;
    logic [SW-1:0] sel_idx;
    t_entry        sel_word;
    t_out_item     r_res;
    logic          r_out_valid;
    t_out_item     r_out;

    assign slot_idx = SW'(r_item.slot);
    assign in_rng   = (32'(r_item.slot) < SLOTS);
    assign now32    = {1'b0, r_item.now};
    assign is_scan  = (i_cmd.op == OP_SCAN1) || (i_cmd.op == OP_SCAN2);
    assign ra       = is_scan ? r_cnt : slot_idx;
    assign eff      = r_rd_vld ? r_rd_word : ENTRY_RESET;
    assign wait32   = now32 - {1'b0, eff.entered};
    assign age      = eff.runnable && (wait32 >= {1'b0, i_thr});
    assign w_next   = r_w - $signed({24'd0, eff.tickets});

    // Pick the winner in priority order: level one, lottery, first come
    always_comb begin
        sel_found = 1'b1;
        sel_idx   = r_fc_idx;
        sel_word  = r_fc_word;
        if (r_p1_hit) begin
            sel_idx  = r_p1_idx;
            sel_word = r_p1_word;
        end else if (r_lot_hit) begin
            sel_idx  = r_lot_idx;
            sel_word = r_lot_word;
        end else if (!r_fc_hit) begin
            sel_found = 1'b0;
        end
    end

    // Table write port
    always_comb begin
        we = 1'b0;
        wa = r_pidx;
        wd = eff;
        case (i_cmd.op)
            OP_SET_WR: begin
                we = in_rng;
                wa = slot_idx;
                case (r_item.func)
                    FUNC_ADMIT: begin
                        wd = '{runnable: 1'b1, level: LEVEL_LOT,
                               entered: r_item.now, tickets: r_item.tickets};
                    end
                    FUNC_SET_RUN: wd.runnable = r_item.runnable;
                    FUNC_SET_LVL: wd.level    = r_item.level;
                    default:      wd.tickets  = r_item.tickets;
                endcase
            end
            OP_SCAN1: begin
                we = r_pv && age;
                wd.level   = LEVEL_RR;
                wd.entered = r_item.now;
            end
            OP_COMMIT: begin
                we = sel_found;
                wa = sel_idx;
                wd = sel_word;
                wd.runnable = 1'b0;
                wd.entered  = r_item.now;
            end
            default: ;
        endcase
    end

    // Table storage with registered read
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        r_rd_word <= mem[ra];
    end

    // Valid bits: an unwritten entry reads as the reset entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (we) begin
                r_valid[wa] <= 1'b1;
            end
            r_rd_vld <= r_valid[ra];
        end
    end

    // Capture the accepted item
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LATCH) begin
            r_item <= i_in_item;
        end
    end

    // Advance the scan address, one read per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issuing <= 1'b0;
            r_pv      <= 1'b0;
            r_cnt     <= '0;
            r_pidx    <= '0;
        end else begin
            r_pv   <= r_issuing;
            r_pidx <= r_cnt;
            if (is_scan && i_cmd.start) begin
                r_issuing <= 1'b1;
                r_cnt     <= '0;
            end else if (r_issuing) begin
                if (r_cnt == LAST) begin
                    r_issuing <= 1'b0;
                end else begin
                    r_cnt <= r_cnt + SW'(1);
                end
            end
        end
    end

    // Aging, level one pick, ticket total, lottery walk, first come pick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_hit  <= 1'b0;
            r_lot_hit <= 1'b0;
            r_fc_hit  <= 1'b0;
        end else if (i_cmd.op == OP_SCAN1) begin
            if (i_cmd.start) begin
                r_p1_hit  <= 1'b0;
                r_lot_hit <= 1'b0;
                r_fc_hit  <= 1'b0;
                r_best    <= '0;
                r_total   <= '0;
            end else if (r_pv && !age && eff.runnable) begin
                if (eff.level == LEVEL_RR && wait32[30:0] > r_best) begin
                    r_best    <= wait32[30:0];
                    r_p1_hit  <= 1'b1;
                    r_p1_idx  <= r_pidx;
                    r_p1_word <= eff;
                end else if (eff.level == LEVEL_LOT) begin
                    r_total <= r_total + TW'(eff.tickets);
                end
            end
        end else if (i_cmd.op == OP_SCAN2) begin
            if (i_cmd.start) begin
                r_w  <= {{2{r_draw[31]}}, r_draw};
                r_mn <= FCFS_LIMIT;
            end else if (r_pv && eff.runnable) begin
                if (eff.level == LEVEL_LOT && !r_lot_hit) begin
                    r_w <= w_next;
                    if (w_next[33] || w_next == 34'sd0) begin
                        r_lot_hit  <= 1'b1;
                        r_lot_idx  <= r_pidx;
                        r_lot_word <= eff;
                    end
                end else if (eff.level == LEVEL_FCFS && eff.entered < r_mn) begin
                    r_mn      <= eff.entered;
                    r_fc_hit  <= 1'b1;
                    r_fc_idx  <= r_pidx;
                    r_fc_word <= eff;
                end
            end
        end
    end

    // Select the remainder operand
    always_comb begin
        div_start = 1'b0;
        div_in    = $signed(r_prod);
        case (i_cmd.op)
            OP_DIV_A: begin
                div_start = i_cmd.start;
                div_in    = $signed(now32 + 32'd2);
            end
            OP_DIV_E: begin
                div_start = i_cmd.start;
                div_in    = $signed(r_prod + 32'd1);
            end
            OP_DIV_F: begin
                div_start = i_cmd.start;
                div_in    = $signed(now32);
            end
            OP_DIV_R: div_start = i_cmd.start;
            default: ;
        endcase
    end

    mls_div #(.DW(TW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_in),
        .i_divisor  (r_total),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    // Lottery draw steps, one multiply per cycle
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_DRAW_INIT: r_draw <= $signed(32'(r_total));
            OP_DIV_A: if (div_done) r_a <= div_rem;
            OP_MUL_A: r_prod <= r_a * (now32 + 32'd1);
            OP_MUL_K: r_prod <= r_prod * DRAW_MULT;
            OP_DIV_E: if (div_done) r_e <= div_rem + 32'sd1;
            OP_DIV_F: if (div_done) r_f <= div_rem + 32'sd1;
            OP_MUL_R: r_prod <= r_e * r_f;
            OP_DIV_R: if (div_done) r_draw <= div_rem + 32'sd1;
            default: ;
        endcase
    end

    // Result of the current item
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LATCH) begin
            r_res <= '0;
        end else if (i_cmd.op == OP_COMMIT && sel_found) begin
            r_res.found        <= 1'b1;
            r_res.chosen_slot  <= 6'(sel_idx);
            r_res.chosen_level <= sel_word.level;
        end
    end

    // Output register: hold until the transfer completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == OP_LOAD_OUT) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD_OUT) begin
            r_out <= r_res;
        end
    end

    assign o_stat.scan_done   = r_pv && (r_pidx == LAST);
    assign o_stat.div_done    = div_done;
    assign o_stat.pick1       = r_p1_hit;
    assign o_stat.small_total = (r_total <= TW'(1));
    assign o_stat.out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid        = r_out_valid;
    assign o_out_item         = r_out;

endmodule

>>> rtl/mls_ctrl.sv
// Controller: sequences item handling, table scans and the lottery draw.
module mls_ctrl import mls_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic [2:0] i_func,
    input  t_mls_stat i_stat,
    output t_mls_cmd  o_cmd,
    output logic      o_idle
);

    typedef enum logic [3:0] {
        S_IDLE, S_SET_RD, S_SET_WR, S_SCAN1, S_DRAW_CHK, S_DIV_A, S_MUL_A,
        S_MUL_K, S_DIV_E, S_DIV_F, S_MUL_R, S_DIV_R, S_SCAN2, S_COMMIT, S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_first;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_func) inside
                        FUNC_ADMIT: n_state = S_SET_WR;
                        FUNC_SET_RUN, FUNC_SET_LVL, FUNC_SET_TIX: n_state = S_SET_RD;
                        FUNC_SCHED: n_state = S_SCAN1;
                        default:    n_state = S_DONE;
                    endcase
                end
            end
            S_SET_RD: n_state = S_SET_WR;
            S_SET_WR: n_state = S_DONE;
            S_SCAN1:  if (i_stat.scan_done) n_state = S_DRAW_CHK;
            S_DRAW_CHK: begin
                if (i_stat.pick1) begin
                    n_state = S_COMMIT;
                end else if (i_stat.small_total) begin
                    n_state = S_SCAN2;
                end else begin
                    n_state = S_DIV_A;
                end
            end
            S_DIV_A:  if (i_stat.div_done) n_state = S_MUL_A;
            S_MUL_A:  n_state = S_MUL_K;
            S_MUL_K:  n_state = S_DIV_E;
            S_DIV_E:  if (i_stat.div_done) n_state = S_DIV_F;
            S_DIV_F:  if (i_stat.div_done) n_state = S_MUL_R;
            S_MUL_R:  n_state = S_DIV_R;
            S_DIV_R:  if (i_stat.div_done) n_state = S_SCAN2;
            S_SCAN2:  if (i_stat.scan_done) n_state = S_COMMIT;
            S_COMMIT: n_state = S_DONE;
            S_DONE:   if (i_stat.out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Hold state and the first-cycle flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_first <= 1'b0;
        end else begin
            r_state <= n_state;
            r_first <= (n_state != r_state);
        end
    end

    // Decode the datapath operation
    always_comb begin
        o_cmd.start = r_first;
        unique case (r_state)
            S_IDLE:     o_cmd.op = i_in_valid ? OP_LATCH : OP_NONE;
            S_SET_RD:   o_cmd.op = OP_SET_RD;
            S_SET_WR:   o_cmd.op = OP_SET_WR;
            S_SCAN1:    o_cmd.op = OP_SCAN1;
            S_DRAW_CHK: o_cmd.op = OP_DRAW_INIT;
            S_DIV_A:    o_cmd.op = OP_DIV_A;
            S_MUL_A:    o_cmd.op = OP_MUL_A;
            S_MUL_K:    o_cmd.op = OP_MUL_K;
            S_DIV_E:    o_cmd.op = OP_DIV_E;
            S_DIV_F:    o_cmd.op = OP_DIV_F;
            S_MUL_R:    o_cmd.op = OP_MUL_R;
            S_DIV_R:    o_cmd.op = OP_DIV_R;
            S_SCAN2:    o_cmd.op = OP_SCAN2;
            S_COMMIT:   o_cmd.op = OP_COMMIT;
            S_DONE:     o_cmd.op = i_stat.out_free ? OP_LOAD_OUT : OP_NONE;
            default:    o_cmd.op = OP_NONE;
        endcase
    end

    assign o_idle = (r_state == S_IDLE);

endmodule

>>> rtl/multilevel_lottery_scheduler_core.sv
// Top level of the multilevel lottery scheduler: config port, controller and datapath.
//
// The block takes one item at a time. Admit writes the slot table and the set operations
// read and then write it, and each loads the result register after. A schedule item walks
// the slot table once; when level one yields a slot it finishes there. Otherwise a lottery
// draw of four serial remainders (one quotient bit per cycle) and three multiplies
// follows, then a second walk of the table. The single-read slot table and the bit-serial
// remainder unit set the pace. A finished result waits in an output register while the
// next item enters.
module multilevel_lottery_scheduler_core import mls_pkg::*; #(
    parameter int SLOTS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  t_in_item    i_in_item,
    output logic        o_in_stall,
    output logic        o_out_valid,
    output t_out_item   o_out_item,
    input  logic        i_out_stall,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic REG_THR = 1'b0;

    logic [30:0] r_thr;
    t_mls_cmd    cmd;
    t_mls_stat   stat;
    logic        idle;

    // Starvation threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_THR) begin
            r_thr <= pwdata[30:0];
        end
    end

    assign pready     = 1'b1;
    assign prdata     = (paddr[2] == REG_THR) ? {1'b0, r_thr} : 32'd0;
    assign o_in_stall = !idle;

    mls_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_in_item.func),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_idle     (idle)
    );

    mls_datapath #(.SLOTS(SLOTS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_item   (i_in_item),
        .i_thr       (r_thr),
        .i_out_stall (i_out_stall),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

>>> rtl/mls_checker.sv
// Port-level checker of the scheduler core and its bind.
module mls_checker import mls_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input t_out_item o_out_item,
    input logic      i_out_stall
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // One item at a time: after a transfer in, the input stalls
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after transfer");

    // Empty result carries no slot
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.found |->
            o_out_item.chosen_slot == 6'd0 && o_out_item.chosen_level == 2'd0)
        else $error("empty result with payload");

    // A picked slot comes from a real level
    a_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.found |-> o_out_item.chosen_level != 2'd0)
        else $error("pick from level zero");

endmodule

bind multilevel_lottery_scheduler_core mls_checker u_mls_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_item  (o_out_item),
    .i_out_stall (i_out_stall)
);

>>> sim/multilevel_lottery_scheduler_core_tb.sv
// Self-checking testbench for the multilevel lottery scheduler core.
module multilevel_lottery_scheduler_core_tb;
    import mls_pkg::*;

    localparam int NSLOT      = 64;
    localparam int DRAIN_WAIT = 2 * NSLOT + 300;
    localparam int CYCLE_MAX  = 3000000;
    localparam int IW         = $bits(t_in_item);

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    t_in_item    i_in_item = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    t_out_item   o_out_item;
    logic        i_out_stall = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    multilevel_lottery_scheduler_core #(.SLOTS(NSLOT)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_item(i_in_item), .o_in_stall(o_in_stall),
        .o_out_valid(o_out_valid), .o_out_item(o_out_item), .i_out_stall(i_out_stall),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 i_clk = ~i_clk;

    // Scheduler shadow: slot table and threshold
    logic        tbl_run [NSLOT];
    logic [1:0]  tbl_lvl [NSLOT];
    logic [31:0] tbl_ent [NSLOT];
    logic [9:0]  tbl_tix [NSLOT];
    logic [31:0] shadow_thr;

    t_in_item  pending_items [$];
    t_out_item expected_picks [$];
    int        mismatches = 0;
    int        cycle_cnt = 0;
    int        send_gap = 0;
    int        stall_left = 0;
    bit        quiet = 1'b0;
    logic [31:0] tick;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("MISMATCH %s: got %0d want %0d at cycle %0d", what, got, want, cycle_cnt);
        mismatches++;
    endtask

    function automatic int draw_value(input int total, input logic [31:0] now);
        int a, b, c, e, f, r;
        if (total <= 1) return total;
        a = int'(now + 32'd2) % total;
        b = a * int'(now + 32'd1);
        b = b * int'(DRAW_MULT);
        c = b + 1;
        e = 1 + c % total;
        f = 1 + int'(now) % total;
        r = e * f;
        return r % total + 1;
    endfunction

    // Apply one item to the shadow table and return its result
    function automatic t_out_item predict_pick(input t_in_item it);
        t_out_item   res;
        logic [31:0] now;
        int          pick, total;
        longint      best, waitv, w;
        logic [31:0] mn;
        res = '0;
        now = {1'b0, it.now};
        pick = -1;
        case (it.func)
            FUNC_ADMIT: begin
                tbl_run[it.slot] = 1'b1;
                tbl_lvl[it.slot] = LEVEL_LOT;
                tbl_ent[it.slot] = now;
                tbl_tix[it.slot] = it.tickets;
            end
            FUNC_SET_RUN: tbl_run[it.slot] = it.runnable;
            FUNC_SET_LVL: tbl_lvl[it.slot] = it.level;
            FUNC_SET_TIX: tbl_tix[it.slot] = it.tickets;
            FUNC_SCHED: begin
                // age long waiters into level one
                for (int i = 0; i < NSLOT; i++)
                    if (tbl_run[i] && (now - tbl_ent[i]) >= shadow_thr) begin
                        tbl_lvl[i] = LEVEL_RR;
                        tbl_ent[i] = now;
                    end
                best = 0;
                for (int i = 0; i < NSLOT; i++)
                    if (tbl_run[i] && tbl_lvl[i] == LEVEL_RR) begin
                        waitv = longint'(now) - longint'(tbl_ent[i]);
                        if (waitv > best) begin
                            best = waitv;
                            pick = i;
                        end
                    end
                if (pick < 0) begin
                    total = 0;
                    for (int i = 0; i < NSLOT; i++)
                        if (tbl_run[i] && tbl_lvl[i] == LEVEL_LOT) total += int'(tbl_tix[i]);
                    w = draw_value(total, now);
                    for (int i = 0; i < NSLOT; i++)
                        if (pick < 0 && tbl_run[i] && tbl_lvl[i] == LEVEL_LOT) begin
                            w -= longint'(tbl_tix[i]);
                            if (w <= 0) pick = i;
                        end
                end
                if (pick < 0) begin
                    mn = {1'b0, FCFS_LIMIT};
                    for (int i = 0; i < NSLOT; i++)
                        if (tbl_run[i] && tbl_lvl[i] == LEVEL_FCFS && tbl_ent[i] < mn) begin
                            mn = tbl_ent[i];
                            pick = i;
                        end
                end
                if (pick >= 0) begin
                    tbl_ent[pick] = now;
                    tbl_run[pick] = 1'b0;
                    res.found = 1'b1;
                    res.chosen_slot = pick[5:0];
                    res.chosen_level = tbl_lvl[pick];
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic int idle_draw();
        if (quiet || $urandom_range(0, 3) == 0) return 0;
        return int'($urandom_range(0, 13));
    endfunction

    // Cycle limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_MAX) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Driver: predict on each transfer, then present the next item after its gap
    always @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            expected_picks.push_back(predict_pick(i_in_item));
            send_gap = idle_draw();
            if (send_gap == 0 && pending_items.size() > 0) begin
                i_in_item <= pending_items.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end else if (!i_in_valid && i_rst_n) begin
            if (send_gap > 0) begin
                send_gap--;
            end else if (pending_items.size() > 0) begin
                i_in_item <= pending_items.pop_front();
                i_in_valid <= 1'b1;
            end
        end
    end

    // Monitor: compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_out_item want;
        if (o_out_valid && !i_out_stall) begin
            if (expected_picks.size() == 0) begin
                report("unexpected result", 32'(o_out_item), 32'd0);
            end else begin
                want = expected_picks.pop_front();
                if (o_out_item.found !== want.found)
                    report("found", 32'(o_out_item.found), 32'(want.found));
                if (o_out_item.chosen_slot !== want.chosen_slot)
                    report("chosen_slot", 32'(o_out_item.chosen_slot),
                           32'(want.chosen_slot));
                if (o_out_item.chosen_level !== want.chosen_level)
                    report("chosen_level", 32'(o_out_item.chosen_level),
                           32'(want.chosen_level));
            end
            stall_left = idle_draw();
            i_out_stall <= (stall_left != 0);
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= (stall_left != 0);
        end
    end

    task automatic write_threshold(input logic [30:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= '0;
        pwdata <= {1'b0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        shadow_thr = {1'b0, value};
    endtask

    task automatic wait_drained();
        while (pending_items.size() > 0 || i_in_valid || expected_picks.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic push_op(input logic [2:0] f, input logic [5:0] s, input logic [30:0] n,
                           input logic [9:0] tx, input logic [1:0] lv, input logic rn);
        t_in_item it;
        it.func = f;
        it.slot = s;
        it.now = n;
        it.tickets = tx;
        it.level = lv;
        it.runnable = rn;
        pending_items.push_back(it);
    endtask

    // Random phase: mostly admit/schedule traffic on an advancing tick
    task automatic random_phase(input int count);
        t_in_item it;
        int       r;
        for (int k = 0; k < count; k++) begin
            it = IW'({$urandom, $urandom});
            r = $urandom_range(0, 99);
            if (r < 30) it.func = FUNC_ADMIT;
            else if (r < 40) it.func = FUNC_SET_RUN;
            else if (r < 50) it.func = FUNC_SET_LVL;
            else if (r < 57) it.func = FUNC_SET_TIX;
            else if (r < 97) it.func = FUNC_SCHED;
            else it.func = 3'($urandom_range(5, 7));
            if ($urandom_range(0, 3) != 0) it.slot = 6'($urandom_range(0, 11));
            if ($urandom_range(0, 2) != 0) it.tickets = 10'($urandom_range(0, 20));
            if ($urandom_range(0, 4) != 0) it.level = 2'($urandom_range(1, 3));
            // advance the tick, with rare jumps anywhere in range
            if ($urandom_range(0, 40) == 0) tick = {1'b0, 31'($urandom)};
            else tick = {1'b0, 31'(tick + $urandom_range(0, 3000))};
            if ($urandom_range(0, 20) != 0) it.now = tick[30:0];
            pending_items.push_back(it);
        end
    endtask

    initial begin
        for (int i = 0; i < NSLOT; i++) begin
            tbl_run[i] = 1'b0;
            tbl_lvl[i] = LEVEL_LOT;
            tbl_ent[i] = '0;
            tbl_tix[i] = '0;
        end
        shadow_thr = {1'b0, THR_RESET};
        tick = 32'd100;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty pick, zero-ticket draw, extremes, all levels, unknown codes
        push_op(FUNC_SCHED, 6'd0, 31'd0, 10'd0, 2'd0, 1'b0);
        push_op(FUNC_ADMIT, 6'd0, 31'd10, 10'd0, 2'd0, 1'b0);
        push_op(FUNC_SCHED, 6'd0, 31'd20, 10'd0, 2'd0, 1'b0);
        push_op(FUNC_ADMIT, 6'd63, 31'd30, 10'd1023, 2'd3, 1'b1);
        push_op(FUNC_ADMIT, 6'd1, 31'd31, 10'd1, 2'd0, 1'b0);
        push_op(FUNC_SCHED, 6'd0, 31'd40, 10'd0, 2'd0, 1'b0);
        push_op(FUNC_SCHED, 6'd0, 31'd41, 10'd0, 2'd0, 1'b0);
        push_op(FUNC_ADMIT, 6'd5, 31'd50, 10'd7, 2'd0, 1'b0);
        push_op(FUNC_SET_LVL, 6'd5, 31'd0, 10'd0, LEVEL_FCFS, 1'b0);
        push_op(FUNC_ADMIT, 6'd6, 31'd60, 10'd7, 2'd0, 1'b0);
        push_op(FUNC_SET_LVL, 6'd6, 31'd0, 10'd0, 2'd0, 1'b0);
        push_op(FUNC_SET_RUN, 6'd63, 31'd0, 10'd0, 2'd0, 1'b0);
        push_op(FUNC_SET_RUN, 6'd1, 31'd0, 10'd0, 2'd0, 1'b1);
        push_op(FUNC_SET_TIX, 6'd1, 31'd0, 10'd1023, 2'd0, 1'b0);
        push_op(FUNC_SCHED, 6'd0, 31'd70, 10'd0, 2'd0, 1'b0);
        push_op(FUNC_SCHED, 6'd0, 31'd80, 10'd0, 2'd0, 1'b0);
        push_op(3'd5, 6'd63, 31'h7fffffff, 10'd1023, 2'd3, 1'b1);
        push_op(3'd6, 6'd2, 31'd0, 10'd0, 2'd0, 1'b0);
        push_op(3'd7, 6'd3, 31'd5, 10'd5, 2'd1, 1'b1);
        // aging into level one, then a second level-one slot with the same wait
        push_op(FUNC_SCHED, 6'd0, 31'd9000, 10'd0, 2'd0, 1'b0);
        push_op(FUNC_ADMIT, 6'd9, 31'd9000, 10'd3, 2'd0, 1'b0);
        push_op(FUNC_SET_LVL, 6'd9, 31'd0, 10'd0, LEVEL_RR, 1'b0);
        push_op(FUNC_SCHED, 6'd0, 31'd9500, 10'd0, 2'd0, 1'b0);
        push_op(FUNC_SCHED, 6'd0, 31'h7fffffff, 10'd0, 2'd0, 1'b0);
        random_phase(200);
        wait_drained();

        write_threshold(31'd1);
        quiet = 1'b1;
        random_phase(250);
        wait_drained();

        write_threshold(31'h7fffffff);
        quiet = 1'b0;
        random_phase(300);
        wait_drained();

        write_threshold(31'($urandom_range(100, 20000)));
        random_phase(300);
        wait_drained();

        write_threshold(31'($urandom_range(1, 32'h7fffffff)));
        random_phase(150);
        wait_drained();

        write_threshold(THR_RESET);
        random_phase(330);
        wait_drained();

        if (mismatches == 0 && expected_picks.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/mls_pkg.sv
rtl/mls_div.sv
rtl/mls_datapath.sv
rtl/mls_ctrl.sv
rtl/multilevel_lottery_scheduler_core.sv
rtl/mls_checker.sv
sim/multilevel_lottery_scheduler_core_tb.sv
